>>> sv/stk_pkg.sv
// Shared types and constants for the LIFO stack with unique push and remove.
`timescale 1ns / 1ps

package stk_pkg;

  localparam int WORD_W = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 3;
  localparam int CNT_OUT_W = 7;

  // Word returned when a pop or peek finds the stack empty.
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH        = 3'd0,
    ACT_PUSH_UNIQUE = 3'd1,
    ACT_POP         = 3'd2,
    ACT_REMOVE      = 3'd3,
    ACT_PEEK        = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_DUP      = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // What every cell of the row does at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_PUSH   = 2'd1,
    CELL_POP    = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [WORD_W-1:0]  key;
  } cell_ctrl_t;

endpackage

>>> sv/stk_req_if.sv
// Request and response channel interfaces of the stack.
`timescale 1ns / 1ps

interface stk_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [stk_pkg::ACTION_W-1:0]           action;
  logic signed [stk_pkg::WORD_W-1:0]      value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface stk_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [stk_pkg::WORD_W-1:0]      result_value;
  logic [stk_pkg::STATUS_W-1:0]           status;
  logic [stk_pkg::CNT_OUT_W-1:0]          entry_count;

  modport source (output valid, output result_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input result_value, input status, input entry_count,
                  output ready);
endinterface

>>> sv/stack_with_unique_push_and_remove.sv
// Top level of the LIFO stack with unique push and remove, built as a row of cells.
// Response: a request is answered in the cycle after its transaction, from the output register.
// Throughput: one request per cycle while the response is not stalled; the compare chain
// through all STACK_DEPTH cells and the row shift together set the cycle time.
// Reset: rst_ni (asynchronous, active low) empties the stack and the output register;
// the cell words are not cleared, since only cells below the fill count are ever read.
`timescale 1ns / 1ps

module stack_with_unique_push_and_remove #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stk_req_if.sink   req_i,
  stk_rsp_if.source rsp_o
);

  localparam int CntW    = $clog2(STACK_DEPTH + 1);
  localparam int CntOutW = stk_pkg::CNT_OUT_W;
  localparam logic [CntW-1:0] DepthC = CntW'(STACK_DEPTH);

  // The top of the stack always sits in cell 0. A push shifts every cell one place
  // deeper, a pop shifts every cell one place toward the top, and a remove shifts
  // only the cells from the match downward, which closes the gap.
  logic signed [stk_pkg::WORD_W-1:0] cell_data [STACK_DEPTH];
  logic [STACK_DEPTH:0]              hit_chain;
  stk_pkg::cell_ctrl_t               cell_ctrl;

  logic [CntW-1:0] count_q, count_d;

  logic                              rsp_valid_q;
  logic signed [stk_pkg::WORD_W-1:0] rsp_value_q, rsp_value_d;
  stk_pkg::status_e                  rsp_status_q, rsp_status_d;
  logic [CntOutW-1:0]                rsp_count_q;

  logic req_accept;
  logic stack_full;
  logic stack_empty;
  logic any_hit;

  // A new request is taken whenever the output register is free or is being drained.
  assign req_i.ready = ~rsp_valid_q | rsp_o.ready;
  assign req_accept  = req_i.valid & req_i.ready;

  assign stack_full  = count_q == DepthC;
  assign stack_empty = count_q == '0;

  // The match flag ripples from the top cell downward; cells below the first match
  // see it set, and the end of the chain tells whether the value is stored at all.
  assign hit_chain[0] = 1'b0;
  assign any_hit      = hit_chain[STACK_DEPTH];

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic signed [stk_pkg::WORD_W-1:0] upper_w, lower_w;

    if (g == 0) begin : g_top
      assign upper_w = req_i.value;
    end else begin : g_mid
      assign upper_w = cell_data[g-1];
    end

    // The deepest cell has no neighbor below; what it takes on a shift is dead data.
    if (g == STACK_DEPTH - 1) begin : g_bot
      assign lower_w = cell_data[g];
    end else begin : g_inner
      assign lower_w = cell_data[g+1];
    end

    stk_cell #(
      .STACK_DEPTH(STACK_DEPTH),
      .IDX        (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .count_i(count_q),
      .upper_i(upper_w),
      .lower_i(lower_w),
      .hit_i  (hit_chain[g]),
      .data_o (cell_data[g]),
      .hit_o  (hit_chain[g+1])
    );
  end

  // Decode the request into a row command, the next fill count and the response.
  always_comb begin
    cell_ctrl.op  = stk_pkg::CELL_HOLD;
    cell_ctrl.key = req_i.value;
    count_d       = count_q;
    rsp_value_d   = '0;
    rsp_status_d  = stk_pkg::ST_OK;

    if (req_accept) begin
      case (stk_pkg::action_e'(req_i.action))
        stk_pkg::ACT_PUSH: begin
          if (stack_full) begin
            rsp_status_d = stk_pkg::ST_FULL;
          end else begin
            cell_ctrl.op = stk_pkg::CELL_PUSH;
            count_d      = count_q + 1'b1;
          end
        end
        stk_pkg::ACT_PUSH_UNIQUE: begin
          // The duplicate check wins over the full check.
          if (any_hit) begin
            rsp_status_d = stk_pkg::ST_DUP;
          end else if (stack_full) begin
            rsp_status_d = stk_pkg::ST_FULL;
          end else begin
            cell_ctrl.op = stk_pkg::CELL_PUSH;
            count_d      = count_q + 1'b1;
          end
        end
        stk_pkg::ACT_POP: begin
          if (stack_empty) begin
            rsp_value_d  = stk_pkg::EMPTY_WORD;
            rsp_status_d = stk_pkg::ST_EMPTY;
          end else begin
            rsp_value_d  = cell_data[0];
            cell_ctrl.op = stk_pkg::CELL_POP;
            count_d      = count_q - 1'b1;
          end
        end
        stk_pkg::ACT_REMOVE: begin
          if (!any_hit) begin
            rsp_status_d = stk_pkg::ST_NOTFOUND;
          end else begin
            cell_ctrl.op = stk_pkg::CELL_REMOVE;
            count_d      = count_q - 1'b1;
          end
        end
        stk_pkg::ACT_PEEK: begin
          if (stack_empty) begin
            rsp_value_d  = stk_pkg::EMPTY_WORD;
            rsp_status_d = stk_pkg::ST_EMPTY;
          end else begin
            rsp_value_d = cell_data[0];
          end
        end
        default: begin
          // Unused action codes leave everything unchanged and report success.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (req_accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload is loaded with each request transaction and needs no reset.
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      rsp_value_q  <= rsp_value_d;
      rsp_status_q <= rsp_status_d;
      rsp_count_q  <= CntOutW'(count_d);
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.result_value = rsp_value_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.entry_count  = rsp_count_q;

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("fill count exceeds stack depth");

  // A successful remove takes exactly one entry away.
  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_accept && req_i.action == stk_pkg::ACT_REMOVE && any_hit)
    |=> count_q == $past(count_q) - 1'b1)
    else $error("remove did not shrink the stack by one");

  // A push that is not dropped puts the pushed word on top.
  a_push_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_accept && req_i.action == stk_pkg::ACT_PUSH && !stack_full)
    |=> cell_data[0] == $past(req_i.value))
    else $error("pushed word missing from top of stack");

  // A transaction is never accepted while a response is stuck waiting.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |-> !req_accept)
    else $error("request accepted while response stalled");

endmodule

>>> sv/stk_cell.sv
// One storage cell of the stack row: holds a word, compares it, shifts with its neighbors.
`timescale 1ns / 1ps

module stk_cell #(
  parameter int STACK_DEPTH = 64,
  parameter int IDX         = 0
) (
  input  logic                                clk_i,
  input  stk_pkg::cell_ctrl_t                 ctrl_i,
  input  logic [$clog2(STACK_DEPTH+1)-1:0]    count_i,
  input  logic signed [stk_pkg::WORD_W-1:0]   upper_i,
  input  logic signed [stk_pkg::WORD_W-1:0]   lower_i,
  input  logic                                hit_i,
  output logic signed [stk_pkg::WORD_W-1:0]   data_o,
  output logic                                hit_o
);

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] IdxC = CntW'(IDX);

  logic signed [stk_pkg::WORD_W-1:0] data_q, data_d;
  logic                              occupied;

  // Only cells nearer the top than the fill count hold live entries.
  assign occupied = count_i > IdxC;
  assign hit_o    = hit_i | (occupied & (data_q == ctrl_i.key));
  assign data_o   = data_q;

  always_comb begin
    case (ctrl_i.op)
      stk_pkg::CELL_HOLD:   data_d = data_q;
      stk_pkg::CELL_PUSH:   data_d = upper_i;
      stk_pkg::CELL_POP:    data_d = lower_i;
      stk_pkg::CELL_REMOVE: data_d = hit_o ? lower_i : data_q;
      default:              data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule
